// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the vertex fetch patcher
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define VFSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define VFSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/vfsp_pkg.sv =====
// ---------------------------------------------------------------------------
// vfsp_pkg
// types, codes and constants for the vertex fetch semantic patcher
// ---------------------------------------------------------------------------
`default_nettype none

package vfsp_pkg;

    // default sizing
    localparam int unsigned MAX_ELEMENTS_DEF = 64;
    localparam int unsigned NUM_STREAMS_DEF  = 16;

    // command codes
    typedef enum logic [1:0] {
        CMD_CLEAR       = 2'd0,
        CMD_APPEND      = 2'd1,
        CMD_LOAD_STRIDE = 2'd2,
        CMD_PATCH       = 2'd3
    } vfsp_cmd_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FORMAT
    } vfsp_state_t;

    // one declaration element as stored
    typedef struct packed {
        logic [7:0]  usage;
        logic [7:0]  sem_index;
        logic [3:0]  stream;
        logic [15:0] offset;
        logic [9:0]  type_code;
    } vfsp_elem_t;

    // search outcome handed from sequencer to result formatting
    typedef struct packed {
        logic        load;
        logic        found;
        logic [3:0]  stream;
        logic [15:0] offset;
        logic [9:0]  type_code;
    } vfsp_res_t;

    // bits of the template words that pass through untouched
    localparam logic [31:0] W0_KEEP_MASK = 32'hC00F_FFFF;
    localparam logic [31:0] W1_KEEP_MASK = 32'hBFC0_CFFF;
    localparam logic [31:0] W2_KEEP_MASK = 32'h8000_0000;

    // fetch constant slot is counted down from this value by stream
    localparam logic [6:0] FETCH_CONST_BASE = 7'd95;

    // unbound pattern expressed as an element: stream 0, offset 0, format 6
    localparam logic [9:0] UNBOUND_TYPE = 10'h006;

endpackage

`default_nettype wire

// ===== rtl/core/vfsp_elem_mem.sv =====
// ---------------------------------------------------------------------------
// vfsp_elem_mem
// declaration element ram, one write port and one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module vfsp_elem_mem #(
    parameter int unsigned DEPTH = vfsp_pkg::MAX_ELEMENTS_DEF,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_W-1:0]    wr_addr,
    input  wire vfsp_pkg::vfsp_elem_t wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_W-1:0]    rd_addr,
    output vfsp_pkg::vfsp_elem_t      rd_data
);

    vfsp_pkg::vfsp_elem_t elem_mem [DEPTH];
    vfsp_pkg::vfsp_elem_t rd_data_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            elem_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= elem_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/vfsp_stride_tbl.sv =====
// ---------------------------------------------------------------------------
// vfsp_stride_tbl
// per-stream stride registers, cleared on reset, out-of-range reads give 0
// ---------------------------------------------------------------------------
`default_nettype none

module vfsp_stride_tbl #(
    parameter int unsigned NUM_STREAMS = vfsp_pkg::NUM_STREAMS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr_en,
    input  wire logic [3:0] wr_stream,
    input  wire logic [7:0] wr_data,
    input  wire logic [3:0] rd_stream,
    output logic      [7:0] rd_data
);

    localparam int unsigned SIDX_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

    logic [7:0] stride_reg [NUM_STREAMS];
    logic       wr_in_range;
    logic       rd_in_range;

    assign wr_in_range = {1'b0, wr_stream} < 5'(NUM_STREAMS);
    assign rd_in_range = {1'b0, rd_stream} < 5'(NUM_STREAMS);

    // stride writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < int'(NUM_STREAMS); i++)
            begin
                stride_reg[i] <= '0;
            end
        end
        else if (wr_en && wr_in_range)
        begin
            stride_reg[wr_stream[SIDX_W-1:0]] <= wr_data;
        end
    end

    // missing streams read as zero stride
    assign rd_data = rd_in_range ? stride_reg[rd_stream[SIDX_W-1:0]] : 8'd0;

endmodule

`default_nettype wire

// ===== rtl/core/vfsp_seq.sv =====
// ---------------------------------------------------------------------------
// vfsp_seq
// command sequencer: element count, append writes, and the linear search
// that walks the element ram one entry a cycle through a single comparator
// ---------------------------------------------------------------------------
`default_nettype none

module vfsp_seq #(
    parameter int unsigned MAX_ELEMENTS = vfsp_pkg::MAX_ELEMENTS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    input  wire logic [1:0]           command,
    input  wire vfsp_pkg::vfsp_elem_t append_elem,
    input  wire logic [3:0]           key_usage,
    input  wire logic [3:0]           key_sem_index,
    input  wire logic                 out_free,
    output logic                      busy,
    output vfsp_pkg::vfsp_res_t       res
);

    localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int unsigned IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    vfsp_pkg::vfsp_state_t state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      issue_reg, issue_next;
    logic                  chk_vld_reg, chk_vld_next;
    logic                  found_reg, found_next;
    logic [3:0]            key_usage_reg, key_usage_next;
    logic [3:0]            key_uidx_reg, key_uidx_next;
    vfsp_pkg::vfsp_elem_t  hit_reg, hit_next;

    logic                  accept;
    logic                  not_full;
    logic                  wr_en;
    logic                  rd_en;
    logic                  match;
    vfsp_pkg::vfsp_elem_t  rd_data;
    vfsp_pkg::vfsp_elem_t  unbound_elem;

    assign busy     = (state_reg != vfsp_pkg::ST_IDLE);
    assign accept   = req_valid && !busy;
    assign not_full = count_reg < CNT_W'(MAX_ELEMENTS);
    assign wr_en    = accept && (command == vfsp_pkg::CMD_APPEND) && not_full;
    assign rd_en    = (state_reg == vfsp_pkg::ST_SCAN) && (issue_reg < count_reg);

    // the shared comparator, fed one stored element per cycle
    assign match = chk_vld_reg
                && (rd_data.usage == {4'b0000, key_usage_reg})
                && (rd_data.sem_index == {4'b0000, key_uidx_reg});

    assign unbound_elem = '{usage: 8'd0, sem_index: 8'd0, stream: 4'd0,
                            offset: 16'd0, type_code: vfsp_pkg::UNBOUND_TYPE};

    // element ram
    vfsp_elem_mem #(
        .DEPTH (MAX_ELEMENTS)
    ) u_elem_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (append_elem),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= vfsp_pkg::ST_IDLE;
            count_reg   <= '0;
            issue_reg   <= '0;
            chk_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            issue_reg   <= issue_next;
            chk_vld_reg <= chk_vld_next;
            found_reg   <= found_next;
        end
    end

    // search key and hit payload
    always_ff @(posedge clk)
    begin
        key_usage_reg <= key_usage_next;
        key_uidx_reg  <= key_uidx_next;
        hit_reg       <= hit_next;
    end

    // next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        chk_vld_next   = chk_vld_reg;
        found_next     = found_reg;
        key_usage_next = key_usage_reg;
        key_uidx_next  = key_uidx_reg;
        hit_next       = hit_reg;
        res            = '{load: 1'b0, found: found_reg, stream: hit_reg.stream,
                           offset: hit_reg.offset, type_code: hit_reg.type_code};

        unique case (state_reg)
            vfsp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        vfsp_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        vfsp_pkg::CMD_APPEND:
                        begin
                            if (not_full)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        vfsp_pkg::CMD_PATCH:
                        begin
                            key_usage_next = key_usage;
                            key_uidx_next  = key_sem_index;
                            issue_next     = '0;
                            chk_vld_next   = 1'b0;
                            found_next     = 1'b0;
                            state_next     = vfsp_pkg::ST_SCAN;
                        end
                        default:
                        begin
                            // stride loads are handled by the stride table
                        end
                    endcase
                end
            end

            vfsp_pkg::ST_SCAN:
            begin
                // issue the next read while checking the previous one
                if (rd_en)
                begin
                    issue_next = issue_reg + 1'b1;
                end
                chk_vld_next = rd_en;
                if (match)
                begin
                    found_next   = 1'b1;
                    hit_next     = rd_data;
                    chk_vld_next = 1'b0;
                    state_next   = vfsp_pkg::ST_FORMAT;
                end
                else if (!rd_en && !chk_vld_reg)
                begin
                    found_next = 1'b0;
                    hit_next   = unbound_elem;
                    state_next = vfsp_pkg::ST_FORMAT;
                end
            end

            vfsp_pkg::ST_FORMAT:
            begin
                // wait for the result register to free up
                if (out_free)
                begin
                    res.load   = 1'b1;
                    state_next = vfsp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = vfsp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/vertex_fetch_semantic_patcher.sv =====
// Patch: the scan issues one ram read per element and compares each registered read
// while issuing the next; the first hit or the end of the list moves on to the format state,
// which loads the result; the next beat is taken the cycle after, later while a result is held.
// Clear, append and stride load take one cycle, even while a result waits to leave.
// Reset clears element count, stride table and output valid; element ram is not
// cleared, only entries below the count are ever read.
// ---------------------------------------------------------------------------
// vertex_fetch_semantic_patcher
// declaration search and vertex-fetch triple rewrite, top level
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module vertex_fetch_semantic_patcher #(
    parameter int unsigned MAX_ELEMENTS = vfsp_pkg::MAX_ELEMENTS_DEF,
    parameter int unsigned NUM_STREAMS  = vfsp_pkg::NUM_STREAMS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  elem_usage,
    input  wire logic [7:0]  elem_usage_index,
    input  wire logic [3:0]  stream_number,
    input  wire logic [15:0] elem_byte_offset,
    input  wire logic [9:0]  elem_type_code,
    input  wire logic [7:0]  stride_dwords,
    input  wire logic [19:0] binding_key,
    input  wire logic [31:0] template_word0,
    input  wire logic [31:0] template_word1,
    input  wire logic [31:0] template_word2,
    input  wire logic [31:0] dest_base_addr,

    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic      [31:0] patched_word0,
    output logic      [31:0] patched_word1,
    output logic      [31:0] patched_word2,
    output logic      [31:0] patch_addr,
    output logic             is_bound
);

    logic                 busy;
    logic                 accept;
    logic                 patch_accept;
    logic                 out_free;
    vfsp_pkg::vfsp_elem_t append_elem;
    vfsp_pkg::vfsp_res_t  res;
    logic [7:0]           stride_rd;
    logic [6:0]           fetch_const;
    logic                 unbound_shape_ok;

    logic [31:0] w0_reg, w1_reg, w2_reg, base_reg;
    logic [15:0] fidx12_reg;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] p0_reg, p1_reg, p2_reg, addr_reg;
    logic        bound_reg;

    assign req_stall    = busy;
    assign accept       = req_valid && !busy;
    assign patch_accept = accept && (command == vfsp_pkg::CMD_PATCH);
    assign out_free     = !out_valid_reg || !rsp_stall;

    assign append_elem = '{usage: elem_usage, sem_index: elem_usage_index,
                           stream: stream_number, offset: elem_byte_offset,
                           type_code: elem_type_code};

    // sequencer with element ram
    vfsp_seq #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .command       (command),
        .append_elem   (append_elem),
        .key_usage     (binding_key[15:12]),
        .key_sem_index (binding_key[19:16]),
        .out_free      (out_free),
        .busy          (busy),
        .res           (res)
    );

    // stride table
    vfsp_stride_tbl #(
        .NUM_STREAMS (NUM_STREAMS)
    ) u_stride_tbl (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (accept && (command == vfsp_pkg::CMD_LOAD_STRIDE)),
        .wr_stream (stream_number),
        .wr_data   (stride_dwords),
        .rd_stream (res.stream),
        .rd_data   (stride_rd)
    );

    // template capture, fetch index scaled by 12 up front
    always_ff @(posedge clk)
    begin
        if (patch_accept)
        begin
            w0_reg     <= template_word0;
            w1_reg     <= template_word1;
            w2_reg     <= template_word2;
            base_reg   <= dest_base_addr;
            fidx12_reg <= 16'({binding_key[11:0], 3'b000})
                        + 16'({binding_key[11:0], 2'b00});
        end
    end

    assign fetch_const = vfsp_pkg::FETCH_CONST_BASE - {3'b000, res.stream};

    // result valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload: field rewrite and destination address
    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            p0_reg    <= (w0_reg & vfsp_pkg::W0_KEEP_MASK)
                       | {5'd0, fetch_const, 20'd0};
            p1_reg    <= (w1_reg & vfsp_pkg::W1_KEEP_MASK)
                       | {10'd0, res.type_code[5:0], 2'b00, res.type_code[9:8], 12'd0};
            p2_reg    <= (w2_reg & vfsp_pkg::W2_KEEP_MASK)
                       | {10'd0, res.offset[15:2], stride_rd};
            addr_reg  <= base_reg + {16'd0, fidx12_reg};
            bound_reg <= res.found;
        end
    end

    assign rsp_valid     = out_valid_reg;
    assign patched_word0 = p0_reg;
    assign patched_word1 = p1_reg;
    assign patched_word2 = p2_reg;
    assign patch_addr    = addr_reg;
    assign is_bound      = bound_reg;

    // canned fields of an unbound result
    assign unbound_shape_ok = (patched_word0[26:20] == vfsp_pkg::FETCH_CONST_BASE)
                           && (patched_word1[21:16] == vfsp_pkg::UNBOUND_TYPE[5:0])
                           && (patched_word2[21:8] == 14'd0);

    // checks
    `VFSP_ASSERT_IMP(a_no_overwrite, clk, rst_n, res.load, out_free, "result overwritten")
    `VFSP_ASSERT_NXT(a_busy_after_patch, clk, rst_n, patch_accept, req_stall, "no search")
    `VFSP_ASSERT_IMP(a_unbound_pattern, clk, rst_n, rsp_valid && !is_bound, unbound_shape_ok, "bad unbound")

endmodule

`default_nettype wire
